[design/mlfq_pkg.sv]
package mlfq_pkg;

  localparam int LEVELS_DEF = 4;
  localparam int MAX_THREADS_DEF = 16;
  localparam int ID_W = 4;
  localparam int ID_SPACE = 16;
  localparam int PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_EXPIRE = 2'd1;
  localparam logic [1:0] OP_BLOCK = 2'd2;
  localparam logic [1:0] OP_EXIT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [ID_W-1:0] tid;
  } cmd_t;

endpackage

[design/mlfq_front.sv]
module mlfq_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] op,
  input  logic [mlfq_pkg::ID_W-1:0] thread_id,
  output logic cmd_valid,
  output mlfq_pkg::cmd_t cmd,
  input  logic cmd_take
);

  // two-entry command queue between intake and execution
  mlfq_pkg::cmd_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] cnt;

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wr_ptr] <= '{op: op, tid: thread_id};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (cmd_take && cmd_valid) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push && !full) - 2'(cmd_take && cmd_valid);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (rst) full |-> cmd_valid)
    else $error("full queue must offer a command");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_take) |=> (cmd_valid && $stable(cmd)))
    else $error("waiting command changed");

endmodule

[design/mlfq_back.sv]
module mlfq_back #(
  parameter int LEVELS = mlfq_pkg::LEVELS_DEF,
  parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mlfq_pkg::PERIOD_W-1:0] cfg_data,
  input  logic cmd_valid,
  input  mlfq_pkg::cmd_t cmd,
  output logic cmd_take,
  output logic empty,
  input  logic pop,
  output logic [mlfq_pkg::ID_W-1:0] running_id,
  output logic running_valid,
  output logic [1:0] status,
  output logic aged
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int AW = $clog2(LEVELS * MAX_THREADS);
  localparam int IDW = mlfq_pkg::ID_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RDH = 3'd2;
  localparam logic [2:0] S_AGE = 3'd3;
  localparam logic [2:0] S_AGEW = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [IDW-1:0] mem [LEVELS*MAX_THREADS];
  logic [IDW-1:0] rdata;
  logic [AW-1:0] raddr;

  logic [PW-1:0] head [LEVELS];
  logic [CW-1:0] count [LEVELS];
  logic [LW-1:0] tlev [mlfq_pkg::ID_SPACE];
  logic [IDW-1:0] cur;
  logic cur_v;
  logic [mlfq_pkg::PERIOD_W-1:0] dcount, period;
  logic [2:0] state;
  logic [1:0] st_r;
  logic aged_r, out_full;
  logic [1:0] op_r;
  logic [LW-1:0] sel_lv, age_lv;
  // dispatch scan found a level
  logic took;

  // write port
  logic we;
  logic [LW-1:0] wlv;
  logic [IDW-1:0] wid;

  function automatic logic [AW-1:0] addr_of(logic [LW-1:0] lv, logic [PW-1:0] pos);
    return AW'(lv) * AW'(MAX_THREADS) + AW'(pos);
  endfunction

  function automatic logic [PW-1:0] wrap(logic [PW:0] v);
    logic [PW:0] m;
    m = (v >= (PW+1)'(MAX_THREADS)) ? v - (PW+1)'(MAX_THREADS) : v;
    return m[PW-1:0];
  endfunction

  // best non-empty level
  logic found;
  logic [LW-1:0] best;
  always_comb begin
    found = 1'b0;
    best = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        found = 1'b1;
        best = LW'(i);
      end
    end
  end

  logic [LW-1:0] exp_lv;
  logic l0_room, exp_room;
  assign exp_lv = (tlev[cur] == LW'(LEVELS - 1)) ? tlev[cur] : tlev[cur] + 1'b1;
  assign l0_room = count[0] < CW'(MAX_THREADS);
  assign exp_room = count[exp_lv] < CW'(MAX_THREADS);

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign empty = !out_full;

  always_ff @(posedge clk) begin
    if (we) mem[addr_of(wlv, wrap({1'b0, head[wlv]} + (PW+1)'(count[wlv])))] <= wid;
    rdata <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    wlv = '0;
    wid = cmd.tid;
    raddr = addr_of(best, head[best]);
    unique case (state)
      S_IDLE: begin
        if (cmd_take && cmd.op == mlfq_pkg::OP_ENQ && l0_room) we = 1'b1;
        else if (cmd_take && cmd.op == mlfq_pkg::OP_EXPIRE && cur_v && exp_room) begin
          we = 1'b1;
          wlv = exp_lv;
          wid = cur;
        end
      end
      S_DISP: raddr = addr_of(best, head[best]);
      S_AGE: raddr = addr_of(age_lv, head[age_lv]);
      S_AGEW: begin
        we = 1'b1;
        wid = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        count[i] <= '0;
      end
      for (int i = 0; i < mlfq_pkg::ID_SPACE; i++) tlev[i] <= '0;
      cur <= '0;
      cur_v <= 1'b1;
      dcount <= '0;
      period <= mlfq_pkg::PERIOD_RESET;
      out_full <= 1'b0;
      st_r <= mlfq_pkg::ST_OK;
      aged_r <= 1'b0;
      op_r <= mlfq_pkg::OP_ENQ;
      sel_lv <= '0;
      age_lv <= '0;
      took <= 1'b0;
      running_id <= '0;
      running_valid <= 1'b0;
      status <= mlfq_pkg::ST_OK;
      aged <= 1'b0;
    end else begin
      if (cfg_we) period <= cfg_data;
      if (state == S_OUT && (!out_full || pop)) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            op_r <= cmd.op;
            aged_r <= 1'b0;
            if (cmd.op == mlfq_pkg::OP_ENQ) begin
              if (l0_room) begin
                count[0] <= count[0] + 1'b1;
                tlev[cmd.tid] <= '0;
                st_r <= mlfq_pkg::ST_OK;
              end else st_r <= mlfq_pkg::ST_FULL;
              state <= S_OUT;
            end else begin
              if (cmd.op == mlfq_pkg::OP_EXPIRE && cur_v) begin
                if (exp_room) begin
                  count[exp_lv] <= count[exp_lv] + 1'b1;
                  tlev[cur] <= exp_lv;
                  st_r <= mlfq_pkg::ST_OK;
                end else st_r <= mlfq_pkg::ST_FULL;
              end else st_r <= mlfq_pkg::ST_OK;
              state <= S_DISP;
            end
          end
        end
        S_DISP: begin
          sel_lv <= best;
          took <= found;
          if (found) begin
            head[best] <= wrap({1'b0, head[best]} + 1'b1);
            count[best] <= count[best] - 1'b1;
          end else begin
            cur_v <= 1'b0;
            cur <= '0;
            if (st_r == mlfq_pkg::ST_OK) st_r <= mlfq_pkg::ST_NONE;
          end
          state <= S_RDH;
        end
        S_RDH: begin
          if (took) begin
            cur <= rdata;
            cur_v <= 1'b1;
            tlev[rdata] <= sel_lv;
          end
          if (op_r != mlfq_pkg::OP_EXIT &&
              dcount + 1'b1 >= period) begin
            dcount <= '0;
            aged_r <= 1'b1;
            age_lv <= LW'(1);
            state <= S_AGE;
          end else begin
            if (op_r != mlfq_pkg::OP_EXIT) dcount <= dcount + 1'b1;
            state <= S_OUT;
          end
        end
        S_AGE: begin
          if (age_lv == LW'(0) || !l0_room) state <= S_OUT;
          else if (count[age_lv] == '0) begin
            if (age_lv == LW'(LEVELS - 1)) state <= S_OUT;
            else age_lv <= age_lv + 1'b1;
          end else begin
            head[age_lv] <= wrap({1'b0, head[age_lv]} + 1'b1);
            count[age_lv] <= count[age_lv] - 1'b1;
            state <= S_AGEW;
          end
        end
        S_AGEW: begin
          count[0] <= count[0] + 1'b1;
          tlev[rdata] <= '0;
          state <= S_AGE;
        end
        S_OUT: begin
          if (!out_full || pop) begin
            running_id <= cur_v ? cur : '0;
            running_valid <= cur_v;
            status <= st_r;
            aged <= aged_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rdh: assert property (@(posedge clk) disable iff (rst)
    state == S_DISP |=> state == S_RDH) else $error("dispatch must read head");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_full || pop)) |=> !empty) else $error("result lost");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count[0] <= CW'(MAX_THREADS)) else $error("level 0 overfill");

endmodule

[design/multilevel_feedback_scheduler.sv]
// an enqueue goes from take straight to the result write; an expiry, block or exit passes
// through the level scan and the head read first, and after the head read an aging pass
// moves threads one at a time through an age state and an age-write state, level by level;
// the back end takes a new command only once it has written the result of the last one
// a result that is not popped holds the back end in its output state
// synchronous reset: all levels empty, thread 0 running, aging period 100
module multilevel_feedback_scheduler #(
  parameter int LEVELS = mlfq_pkg::LEVELS_DEF,
  parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] op,
  input  logic [mlfq_pkg::ID_W-1:0] thread_id,
  input  logic cfg_we,
  input  logic [mlfq_pkg::PERIOD_W-1:0] cfg_data,
  output logic empty,
  input  logic pop,
  output logic [mlfq_pkg::ID_W-1:0] running_id,
  output logic running_valid,
  output logic [1:0] status,
  output logic aged
);

  logic cmd_valid, cmd_take;
  mlfq_pkg::cmd_t cmd;

  mlfq_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .thread_id(thread_id),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  mlfq_back #(.LEVELS(LEVELS), .MAX_THREADS(MAX_THREADS)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .empty(empty), .pop(pop), .running_id(running_id),
    .running_valid(running_valid), .status(status), .aged(aged)
  );

endmodule

[tb/sv/tb_multilevel_feedback_scheduler.sv]
module tb_multilevel_feedback_scheduler;

  localparam int NLEV = 4;
  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [mlfq_pkg::ID_W-1:0] rid;
    logic rvalid;
    logic [1:0] st;
    logic ag;
  } sched_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] op = mlfq_pkg::OP_ENQ;
  logic [mlfq_pkg::ID_W-1:0] thread_id = '0;
  logic cfg_we = 1'b0;
  logic [mlfq_pkg::PERIOD_W-1:0] cfg_data = '0;
  logic empty;
  logic pop = 1'b0;
  logic [mlfq_pkg::ID_W-1:0] running_id;
  logic running_valid;
  logic [1:0] status;
  logic aged;

  multilevel_feedback_scheduler dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .thread_id(thread_id),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .empty(empty), .pop(pop),
    .running_id(running_id), .running_valid(running_valid), .status(status), .aged(aged)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // scheduler mirror
  logic [mlfq_pkg::PERIOD_W-1:0] mir_period;
  logic [mlfq_pkg::ID_W-1:0] mir_slot [NLEV][DEPTH];
  int mir_head [NLEV];
  int mir_cnt [NLEV];
  logic [1:0] mir_lvl [mlfq_pkg::ID_SPACE];
  logic [mlfq_pkg::ID_W-1:0] mir_cur;
  logic mir_cur_valid;
  logic [mlfq_pkg::PERIOD_W-1:0] mir_decisions;

  sched_out_t sched_expected [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  function automatic logic [mlfq_pkg::ID_W-1:0] rand_id();
    logic [31:0] v;
    v = $urandom_range(15);
    return v[mlfq_pkg::ID_W-1:0];
  endfunction

  function automatic bit lvl_push(int lv, logic [mlfq_pkg::ID_W-1:0] id);
    if (mir_cnt[lv] >= DEPTH) return 0;
    mir_slot[lv][(mir_head[lv] + mir_cnt[lv]) % DEPTH] = id;
    mir_cnt[lv]++;
    mir_lvl[id] = lv[1:0];
    return 1;
  endfunction

  function automatic logic [mlfq_pkg::ID_W-1:0] lvl_pop(int lv);
    logic [mlfq_pkg::ID_W-1:0] id;
    id = mir_slot[lv][mir_head[lv]];
    mir_head[lv] = (mir_head[lv] + 1) % DEPTH;
    mir_cnt[lv]--;
    return id;
  endfunction

  function automatic void mirror_reset();
    mir_period = mlfq_pkg::PERIOD_RESET;
    for (int l = 0; l < NLEV; l++) begin
      mir_head[l] = 0;
      mir_cnt[l] = 0;
    end
    for (int i = 0; i < mlfq_pkg::ID_SPACE; i++) mir_lvl[i] = '0;
    mir_cur = '0;
    mir_cur_valid = 1'b1;
    mir_decisions = '0;
  endfunction

  function automatic sched_out_t schedule_event(logic [1:0] o,
                                                logic [mlfq_pkg::ID_W-1:0] tid);
    sched_out_t r;
    int nl;
    logic [1:0] st;
    logic ag;
    st = mlfq_pkg::ST_OK;
    ag = 1'b0;
    if (o == mlfq_pkg::OP_ENQ) begin
      if (!lvl_push(0, tid)) st = mlfq_pkg::ST_FULL;
    end else begin
      if (o == mlfq_pkg::OP_EXPIRE && mir_cur_valid) begin
        nl = mir_lvl[mir_cur];
        if (nl + 1 < NLEV) nl++;
        if (!lvl_push(nl, mir_cur)) st = mlfq_pkg::ST_FULL;
      end
      mir_cur_valid = 1'b0;
      mir_cur = '0;
      for (int l = 0; l < NLEV; l++) begin
        if (!mir_cur_valid && mir_cnt[l] != 0) begin
          mir_cur = lvl_pop(l);
          mir_lvl[mir_cur] = l[1:0];
          mir_cur_valid = 1'b1;
        end
      end
      if (!mir_cur_valid && st == mlfq_pkg::ST_OK) st = mlfq_pkg::ST_NONE;
      if (o == mlfq_pkg::OP_EXPIRE || o == mlfq_pkg::OP_BLOCK) begin
        mir_decisions = mir_decisions + 1'b1;
        if (mir_decisions >= mir_period) begin
          for (int l = 1; l < NLEV; l++)
            while (mir_cnt[l] != 0 && mir_cnt[0] < DEPTH) void'(lvl_push(0, lvl_pop(l)));
          mir_decisions = '0;
          ag = 1'b1;
        end
      end
    end
    r.rid = mir_cur_valid ? mir_cur : '0;
    r.rvalid = mir_cur_valid;
    r.st = st;
    r.ag = ag;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // push stays high after an accept so back-to-back items need no gap;
  // anything that waits must drop push first
  task automatic send_item(logic [1:0] o, logic [mlfq_pkg::ID_W-1:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= o;
    thread_id <= tid;
    @(posedge clk);
    while (full) @(posedge clk);
    sched_expected.push_back(schedule_event(o, tid));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_period(logic [mlfq_pkg::PERIOD_W-1:0] p);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    mir_period = p;
  endtask

  // receiver and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (sched_expected.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          sched_out_t w;
          w = sched_expected.pop_front();
          if (running_id !== w.rid)
            report_mismatch("running_id", int'(running_id), int'(w.rid));
          if (running_valid !== w.rvalid)
            report_mismatch("running_valid", int'(running_valid), int'(w.rvalid));
          if (status !== w.st) report_mismatch("status", int'(status), int'(w.st));
          if (aged !== w.ag) report_mismatch("aged", int'(aged), int'(w.ag));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no acceptance on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_multilevel_feedback_scheduler: FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    for (int i = 0; i < 16; i++) send_item(mlfq_pkg::OP_ENQ, i[mlfq_pkg::ID_W-1:0]);
    send_item(mlfq_pkg::OP_ENQ, 4'hf);
    send_item(mlfq_pkg::OP_EXPIRE, 4'h0);
    send_item(mlfq_pkg::OP_BLOCK, 4'h5);
    send_item(mlfq_pkg::OP_EXIT, 4'ha);
    for (int i = 0; i < 3; i++) send_item(mlfq_pkg::OP_EXPIRE, 4'h0);
  endtask

  task automatic test_idle_events();
    // empty every level, then poke with no thread running
    for (int i = 0; i < 40; i++) send_item(mlfq_pkg::OP_EXIT, 4'h0);
    send_item(mlfq_pkg::OP_EXPIRE, 4'h3);
    send_item(mlfq_pkg::OP_BLOCK, 4'hc);
    send_item(mlfq_pkg::OP_EXIT, 4'h0);
    send_item(mlfq_pkg::OP_ENQ, 4'h7);
  endtask

  task automatic test_overflow();
    // fill level 0 and push everything down to the bottom level, then overfill level 0 again
    for (int i = 0; i < 17; i++) send_item(mlfq_pkg::OP_ENQ, i[mlfq_pkg::ID_W-1:0]);
    for (int i = 0; i < 60; i++) send_item(mlfq_pkg::OP_EXPIRE, rand_id());
    for (int i = 0; i < 17; i++) send_item(mlfq_pkg::OP_ENQ, rand_id());
    for (int i = 0; i < 20; i++) send_item(mlfq_pkg::OP_EXPIRE, 4'h0);
  endtask

  task automatic random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) send_item(mlfq_pkg::OP_ENQ, rand_id());
      else if (r < 70) send_item(mlfq_pkg::OP_EXPIRE, rand_id());
      else if (r < 88) send_item(mlfq_pkg::OP_BLOCK, rand_id());
      else send_item(mlfq_pkg::OP_EXIT, rand_id());
    end
  endtask

  task automatic test_aging();
    set_period(16'd1);
    random_burst(120);
    set_period(16'd0);
    random_burst(60);
    set_period(16'd3);
    random_burst(150);
    set_period(16'hffff);
    random_burst(100);
    set_period(16'd7);
  endtask

  task automatic test_random();
    send_idle_pct = 38;
    recv_idle_pct = 87;
    random_burst(350);
    send_idle_pct = 87;
    recv_idle_pct = 38;
    random_burst(300);
    // hold off until the pipeline is empty, then resume
    push <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(250);
  endtask

  initial begin
    mirror_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idle_events();
    test_overflow();
    test_aging();
    test_random();
    drain();
    if (mismatches == 0 && sched_expected.size() == 0) begin
      $display("tb_multilevel_feedback_scheduler: PASS");
    end else begin
      $display("tb_multilevel_feedback_scheduler: FAIL");
    end
    $finish;
  end

endmodule
